FILE: rtl/quaternion_rigid_transform_macros.svh
// Assertion macros shared by the quaternion rigid transform RTL.
`ifndef QUATERNION_RIGID_TRANSFORM_MACROS_SVH
`define QUATERNION_RIGID_TRANSFORM_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define QRT_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define QRT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/qrt_pkg.sv
// Shared types, constants and helpers for the quaternion rigid transform.
package qrt_pkg;

    // Register stage counts of the pipeline sections.
    localparam int POS_LAT   = 4;
    localparam int QUAT_LAT  = 8;
    localparam int ITER_LAT  = 3;
    localparam int SCALE_LAT = 2;

    // Configuration register indexes.
    localparam logic [2:0] REG_ROT_W   = 3'd0;
    localparam logic [2:0] REG_ROT_X   = 3'd1;
    localparam logic [2:0] REG_ROT_Y   = 3'd2;
    localparam logic [2:0] REG_ROT_Z   = 3'd3;
    localparam logic [2:0] REG_SHIFT_X = 3'd4;
    localparam logic [2:0] REG_SHIFT_Y = 3'd5;
    localparam logic [2:0] REG_SHIFT_Z = 3'd6;

    // Per-item data that rides beside the reciprocal square root.
    typedef struct packed {
        logic             op;
        logic             zero;
        logic [3:0][31:0] prod;
        logic [3:0][31:0] orient;
    } qrt_side_t;

    // Saturate to 32 bits signed; bit 32 of the result flags clipping.
    function automatic logic [32:0] sat32(input logic signed [71:0] x);
        logic [32:0] res;
        if (x > 72'sd2147483647) begin
            res = {1'b1, 32'h7FFF_FFFF};
        end else if (x < -72'sd2147483648) begin
            res = {1'b1, 32'h8000_0000};
        end else begin
            res = {1'b0, x[31:0]};
        end
        return res;
    endfunction

endpackage

FILE: rtl/qrt_delay.sv
// Enable-gated shift register that aligns data with the longest pipeline path.
module qrt_delay
    import qrt_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] line_reg [DEPTH];

    // Each stage moves forward only when the pipeline advances.
    always_ff @(posedge aclk) begin
        if (en) begin
            line_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++) begin
                line_reg[i] <= line_reg[i-1];
            end
        end
    end

    assign q = line_reg[DEPTH-1];

endmodule

FILE: rtl/qrt_pos.sv
// Position path: rotate by the stored quaternion, translate, saturate.
module qrt_pos
    import qrt_pkg::*;
(
    input  logic             aclk,
    input  logic             en,
    input  logic [3:0][31:0] rot,
    input  logic [2:0][31:0] shift,
    input  logic [2:0][31:0] pos,
    output logic [2:0][31:0] r,
    output logic             clip
);

    logic signed [31:0] rw, rx, ry, rz, vx, vy, vz;
    logic signed [63:0] a_reg [3];
    logic signed [63:0] b_reg [3];
    logic [2:0][31:0]   v1_reg, v2_reg, v3_reg;
    logic signed [64:0] cs [3];
    logic signed [35:0] t_next [3];
    logic signed [35:0] t_reg [3];
    logic signed [67:0] e_reg [3][3];
    logic signed [69:0] s70 [3];
    logic signed [41:0] rsum [3];
    logic [32:0]        sat [3];
    logic [2:0][31:0]   r_next;
    logic [2:0][31:0]   r_reg;
    logic               clip_reg;

    assign rw = $signed(rot[0]);
    assign rx = $signed(rot[1]);
    assign ry = $signed(rot[2]);
    assign rz = $signed(rot[3]);
    assign vx = $signed(pos[0]);
    assign vy = $signed(pos[1]);
    assign vz = $signed(pos[2]);

    // Stage 1: partial products of the cross product u x v.
    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg[0] <= ry * vz;
            b_reg[0] <= rz * vy;
            a_reg[1] <= rz * vx;
            b_reg[1] <= rx * vz;
            a_reg[2] <= rx * vy;
            b_reg[2] <= ry * vx;
            v1_reg   <= pos;
        end
    end

    // Stage 2: round the cross product to Q16.16 and double it.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            cs[i]     = 65'(a_reg[i]) - 65'(b_reg[i]) + 65'sd536870912;
            t_next[i] = $signed({cs[i][64:30], 1'b0});
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                t_reg[i] <= t_next[i];
            end
            v2_reg <= v1_reg;
        end
    end

    // Stage 3: products of rot_w * t and u x t.
    always_ff @(posedge aclk) begin
        if (en) begin
            e_reg[0][0] <= rw * t_reg[0];
            e_reg[0][1] <= ry * t_reg[2];
            e_reg[0][2] <= rz * t_reg[1];
            e_reg[1][0] <= rw * t_reg[1];
            e_reg[1][1] <= rz * t_reg[0];
            e_reg[1][2] <= rx * t_reg[2];
            e_reg[2][0] <= rw * t_reg[2];
            e_reg[2][1] <= rx * t_reg[1];
            e_reg[2][2] <= ry * t_reg[0];
            v3_reg      <= v2_reg;
        end
    end

    // Stage 4: round once, add position and translation, saturate.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s70[i]    = 70'(e_reg[i][0]) + 70'(e_reg[i][1]) - 70'(e_reg[i][2])
                      + 70'sd536870912;
            rsum[i]   = 42'($signed(s70[i][69:30])) + 42'($signed(v3_reg[i]))
                      + 42'($signed(shift[i]));
            sat[i]    = sat32(72'(rsum[i]));
            r_next[i] = sat[i][31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg    <= r_next;
            clip_reg <= sat[0][32] | sat[1][32] | sat[2][32];
        end
    end

    assign r    = r_reg;
    assign clip = clip_reg;

endmodule

FILE: rtl/qrt_quat.sv
// Orientation front end: Hamilton product, squared norm, normalization and seed.
module qrt_quat
    import qrt_pkg::*;
(
    input  logic             aclk,
    input  logic             en,
    input  logic [3:0][31:0] rot,
    input  logic             op,
    input  logic [3:0][31:0] orient,
    output qrt_side_t        side,
    output logic [5:0]       sh,
    output logic [29:0]      m,
    output logic [31:0]      y0
);

    // Orientation component and sign used by each term of the product.
    localparam logic [1:0] OIDX [4][4] = '{
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd1, 2'd0, 2'd3, 2'd2},
        '{2'd2, 2'd3, 2'd0, 2'd1},
        '{2'd3, 2'd2, 2'd1, 2'd0}
    };
    localparam bit ONEG [4][4] = '{
        '{1'b0, 1'b1, 1'b1, 1'b1},
        '{1'b0, 1'b0, 1'b0, 1'b1},
        '{1'b0, 1'b1, 1'b0, 1'b0},
        '{1'b0, 1'b0, 1'b1, 1'b0}
    };

    logic signed [63:0] pr_reg [4][4];
    logic               op1_reg;
    logic [3:0][31:0]   o1_reg;
    logic signed [65:0] psum [4];
    logic [32:0]        psat [4];
    qrt_side_t          side_next;
    qrt_side_t          side_reg [7];
    logic signed [63:0] sq_full [4];
    logic [62:0]        sq_reg [4];
    logic [64:0]        n65;
    logic [63:0]        n_reg;
    logic [5:0]         top;
    logic [4:0]         half;
    logic               left_next, left_reg;
    logic [5:0]         amt_next, amt_reg;
    logic [5:0]         sh_next;
    logic [5:0]         sh5_reg, sh6_reg, sh7_reg, sh8_reg;
    logic [63:0]        n5_reg;
    logic [63:0]        shifted;
    logic [29:0]        m6_reg, m7_reg, m8_reg;
    logic [63:0]        recip_reg;
    logic [31:0]        y0_reg;

    // Stage 1: the sixteen products of the Hamilton product.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++) begin
                    pr_reg[i][j] <= $signed(rot[j]) * $signed(orient[OIDX[i][j]]);
                end
            end
            op1_reg <= op;
            o1_reg  <= orient;
        end
    end

    // Stage 2: signed sums rounded to Q1.30 and saturated.
    always_comb begin
        side_next.op     = op1_reg;
        side_next.orient = o1_reg;
        for (int i = 0; i < 4; i++) begin
            psum[i] = 66'sd536870912;
            for (int j = 0; j < 4; j++) begin
                if (ONEG[i][j]) begin
                    psum[i] = psum[i] - 66'(pr_reg[i][j]);
                end else begin
                    psum[i] = psum[i] + 66'(pr_reg[i][j]);
                end
            end
            psat[i]           = sat32(72'($signed(psum[i][65:30])));
            side_next.prod[i] = psat[i][31:0];
        end
        side_next.zero = (side_next.prod == '0);
    end

    // Sideband pipeline for stages 2 through 8.
    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side_next;
            for (int i = 1; i < 7; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // Stage 3: squares of the product components.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            sq_full[i] = $signed(side_reg[0].prod[i]) * $signed(side_reg[0].prod[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                sq_reg[i] <= sq_full[i][62:0];
            end
        end
    end

    // Stage 4: squared norm, saturated to 64 bits.
    assign n65 = 65'(sq_reg[0]) + 65'(sq_reg[1]) + 65'(sq_reg[2]) + 65'(sq_reg[3]);

    always_ff @(posedge aclk) begin
        if (en) begin
            n_reg <= n65[64] ? '1 : n65[63:0];
        end
    end

    // Stage 5: leading one position and the even shift that brings the norm near one.
    always_comb begin
        top = '0;
        for (int b = 0; b < 64; b++) begin
            if (n_reg[b]) begin
                top = 6'(b);
            end
        end
        if (top <= 6'd59) begin
            half      = 5'((6'd59 - top) >> 1);
            left_next = 1'b1;
            sh_next   = 6'd30 - 6'(half);
        end else begin
            half      = 5'((top - 6'd58) >> 1);
            left_next = 1'b0;
            sh_next   = 6'd30 + 6'(half);
        end
        amt_next = {half, 1'b0};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n5_reg   <= n_reg;
            left_reg <= left_next;
            amt_reg  <= amt_next;
            sh5_reg  <= sh_next;
        end
    end

    // Stage 6: apply the shift and keep the Q.30 mantissa.
    assign shifted = left_reg ? (n5_reg << amt_reg) : (n5_reg >> amt_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            m6_reg  <= shifted[59:30];
            sh6_reg <= sh5_reg;
        end
    end

    // Stage 7: 4m/3 by multiplying with the reciprocal of three.
    always_ff @(posedge aclk) begin
        if (en) begin
            recip_reg <= 64'({m6_reg, 2'b00}) * 64'(32'hAAAA_AAAB);
            m7_reg    <= m6_reg;
            sh7_reg   <= sh6_reg;
        end
    end

    // Stage 8: linear seed 9/4 - 4m/3.
    always_ff @(posedge aclk) begin
        if (en) begin
            y0_reg  <= 32'd2415919104 - 32'(recip_reg >> 33);
            m8_reg  <= m7_reg;
            sh8_reg <= sh7_reg;
        end
    end

    assign side = side_reg[6];
    assign sh   = sh8_reg;
    assign m    = m8_reg;
    assign y0   = y0_reg;

endmodule

FILE: rtl/qrt_rsqrt.sv
// Newton reciprocal square root, three register stages per iteration.
module qrt_rsqrt
    import qrt_pkg::*;
#(
    parameter int ITERS = 4
) (
    input  logic        aclk,
    input  logic        en,
    input  logic [29:0] m_in,
    input  logic [31:0] y_in,
    output logic [31:0] y_out
);

    localparam logic [32:0] THREE = 33'd3221225472;

    logic [31:0] y_it [ITERS+1];
    logic [29:0] m_it [ITERS];

    assign y_it[0] = y_in;
    assign m_it[0] = m_in;

    for (genvar g = 0; g < ITERS; g++) begin : g_iter
        logic [31:0] ya_reg, yb_reg, yc_reg;
        logic [29:0] ma_reg, mb_reg;
        logic [32:0] yy_reg, my_reg;
        logic [31:0] v;

        // y squared in Q.30.
        always_ff @(posedge aclk) begin
            if (en) begin
                yy_reg <= 33'((64'(y_it[g]) * 64'(y_it[g])) >> 30);
                ya_reg <= y_it[g];
                ma_reg <= m_it[g];
            end
        end

        // m times y squared in Q.30.
        always_ff @(posedge aclk) begin
            if (en) begin
                my_reg <= 33'((63'(ma_reg) * 63'(yy_reg)) >> 30);
                yb_reg <= ya_reg;
                mb_reg <= ma_reg;
            end
        end

        // y * (3 - m y^2) / 2, clamped at zero.
        assign v = (THREE > my_reg) ? 32'(THREE - my_reg) : '0;

        always_ff @(posedge aclk) begin
            if (en) begin
                yc_reg <= 32'((64'(yb_reg) * 64'(v)) >> 31);
            end
        end

        assign y_it[g+1] = yc_reg;

        if (g < ITERS - 1) begin : g_m
            logic [29:0] mc_reg;
            always_ff @(posedge aclk) begin
                if (en) begin
                    mc_reg <= mb_reg;
                end
            end
            assign m_it[g+1] = mc_reg;
        end
    end

    assign y_out = y_it[ITERS];

endmodule

FILE: rtl/qrt_scale.sv
// Orientation back end: scale by the reciprocal norm and pick the result.
module qrt_scale
    import qrt_pkg::*;
(
    input  logic             aclk,
    input  logic             en,
    input  qrt_side_t        side,
    input  logic [5:0]       sh,
    input  logic [31:0]      y,
    output logic [3:0][31:0] orient,
    output logic             degen
);

    logic signed [64:0] prod_reg [4];
    qrt_side_t          side_reg;
    logic [5:0]         sh_reg;
    logic signed [65:0] rnd;
    logic signed [65:0] tot [4];
    logic signed [65:0] shr [4];
    logic [32:0]        psat [4];
    logic [3:0][31:0]   orient_next;
    logic [3:0][31:0]   orient_reg;
    logic               degen_next, degen_reg;

    // Stage 1: product times reciprocal norm.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                prod_reg[i] <= $signed(side.prod[i]) * $signed({1'b0, y});
            end
            side_reg <= side;
            sh_reg   <= sh;
        end
    end

    // Stage 2: round half up by the norm exponent, saturate, select.
    always_comb begin
        rnd = 66'sd1 <<< (sh_reg - 6'd1);
        for (int i = 0; i < 4; i++) begin
            tot[i]  = 66'(prod_reg[i]) + rnd;
            shr[i]  = tot[i] >>> sh_reg;
            psat[i] = sat32(72'(shr[i]));
        end
        degen_next = 1'b0;
        if (!side_reg.op) begin
            orient_next = side_reg.orient;
        end else if (side_reg.zero) begin
            orient_next = side_reg.prod;
            degen_next  = 1'b1;
        end else begin
            for (int i = 0; i < 4; i++) begin
                orient_next[i] = psat[i][31:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            orient_reg <= orient_next;
            degen_reg  <= degen_next;
        end
    end

    assign orient = orient_reg;
    assign degen  = degen_reg;

endmodule

FILE: rtl/quaternion_rigid_transform.sv
// Quaternion rigid transform: top level with configuration registers and stream handshake.
//
// Takes one point or pose per clock unless the output stalls, and returns it rotated by
// the stored unit quaternion and shifted by the stored translation; in pose mode the
// orientation is also premultiplied by the stored rotation and renormalized. The latency
// is set by the orientation path, whose reciprocal square root spends three multiplier
// stages per Newton iteration. The whole pipeline advances together: while a result
// waits on m_tready the pipeline holds and s_tready is low. Configuration writes take
// effect at once, are always accepted, and must be made while no transfer is in flight.
`include "quaternion_rigid_transform_macros.svh"

module quaternion_rigid_transform
    import qrt_pkg::*;
#(
    parameter int NORM_ITERATIONS = 4
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pos_x, pos_y, pos_z, orient_w, orient_x, orient_y, orient_z
    input  logic [223:0] s_tdata,
    // operation
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_pos_x, out_pos_y, out_pos_z, out_orient_w, out_orient_x, out_orient_y,
    // out_orient_z
    output logic [223:0] m_tdata,
    // degenerate, saturated
    output logic [1:0]   m_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int LAT = QUAT_LAT + ITER_LAT * NORM_ITERATIONS + SCALE_LAT;

    logic [3:0][31:0] rot_reg;
    logic [2:0][31:0] shift_reg;
    logic [LAT-1:0]   valid_reg, valid_next;
    logic             pipe_en;
    logic [2:0][31:0] pos_in;
    logic [3:0][31:0] orient_in;
    logic [2:0][31:0] r_pos;
    logic             clip_pos;
    logic [2:0][31:0] r_dly;
    logic             clip_dly;
    qrt_side_t        side_q, side_d;
    logic [5:0]       sh_q, sh_d;
    logic [29:0]      m_q;
    logic [31:0]      y0_q, y_n;
    logic [3:0][31:0] orient_out;
    logic             degen_out;

    assign cfg_ready = 1'b1;

    // Configuration register file; indexes past the list are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rot_reg   <= {32'd0, 32'd0, 32'd0, 32'h4000_0000};
            shift_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_ROT_W:   rot_reg[0]   <= cfg_data;
                REG_ROT_X:   rot_reg[1]   <= cfg_data;
                REG_ROT_Y:   rot_reg[2]   <= cfg_data;
                REG_ROT_Z:   rot_reg[3]   <= cfg_data;
                REG_SHIFT_X: shift_reg[0] <= cfg_data;
                REG_SHIFT_Y: shift_reg[1] <= cfg_data;
                REG_SHIFT_Z: shift_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // The pipeline moves whenever the output stage is empty or being drained.
    assign pipe_en    = !m_tvalid || m_tready;
    assign s_tready   = pipe_en;
    assign valid_next = {valid_reg[LAT-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (pipe_en) begin
            valid_reg <= valid_next;
        end
    end

    assign m_tvalid = valid_reg[LAT-1];

    // Unpack the input transfer.
    assign pos_in    = s_tdata[95:0];
    assign orient_in = s_tdata[223:96];

    // Position path and its alignment to the orientation path.
    qrt_pos u_pos (
        .aclk  (aclk),
        .en    (pipe_en),
        .rot   (rot_reg),
        .shift (shift_reg),
        .pos   (pos_in),
        .r     (r_pos),
        .clip  (clip_pos)
    );

    qrt_delay #(
        .WIDTH (97),
        .DEPTH (LAT - POS_LAT)
    ) u_pos_dly (
        .aclk (aclk),
        .en   (pipe_en),
        .d    ({clip_pos, r_pos}),
        .q    ({clip_dly, r_dly})
    );

    // Orientation path.
    qrt_quat u_quat (
        .aclk   (aclk),
        .en     (pipe_en),
        .rot    (rot_reg),
        .op     (s_tuser[0]),
        .orient (orient_in),
        .side   (side_q),
        .sh     (sh_q),
        .m      (m_q),
        .y0     (y0_q)
    );

    qrt_rsqrt #(
        .ITERS (NORM_ITERATIONS)
    ) u_rsqrt (
        .aclk  (aclk),
        .en    (pipe_en),
        .m_in  (m_q),
        .y_in  (y0_q),
        .y_out (y_n)
    );

    qrt_delay #(
        .WIDTH ($bits(qrt_side_t) + 6),
        .DEPTH (ITER_LAT * NORM_ITERATIONS)
    ) u_side_dly (
        .aclk (aclk),
        .en   (pipe_en),
        .d    ({side_q, sh_q}),
        .q    ({side_d, sh_d})
    );

    qrt_scale u_scale (
        .aclk   (aclk),
        .en     (pipe_en),
        .side   (side_d),
        .sh     (sh_d),
        .y      (y_n),
        .orient (orient_out),
        .degen  (degen_out)
    );

    // Pack the result transfer.
    assign m_tdata = {orient_out, r_dly};
    assign m_tuser = {clip_dly, degen_out};

    `QRT_ASSERT_NEXT(a_accept_enters, aclk, aresetn, s_tvalid && s_tready, valid_reg[0], "accepted transfer did not enter the pipeline")
    `QRT_ASSERT_NEXT(a_stall_holds, aclk, aresetn, !pipe_en, $stable(valid_reg), "pipeline valid bits moved during a stall")
    `QRT_ASSERT_SAME(a_degen_zero, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata[223:96] == '0, "degenerate result carries a nonzero orientation")

endmodule
